@@ rtl/sbb_pkg.sv @@
package sbb_pkg;

  localparam int MAX_RADIUS   = 15;
  localparam int MAX_WIDTH    = 2048;
  localparam int CHANNEL_BITS = 16;
  localparam int NUM_LANES    = 4;
  localparam int WIN_MAX      = 2 * MAX_RADIUS + 1;
  localparam int RAD_W        = 4;
  localparam int SPAN_W       = RAD_W + 1;
  localparam int SLOT_W       = $clog2(WIN_MAX);
  localparam int COL_W        = $clog2(MAX_WIDTH);
  localparam int DIM_W        = 12;
  localparam int SUM_W        = 21;
  localparam int RECIP_W      = 33;
  localparam int RECIP_SHIFT  = 32;
  localparam int STORE_DEPTH  = WIN_MAX * MAX_WIDTH;
  localparam int ADDR_W       = SLOT_W + COL_W;
  localparam int PIX_W        = NUM_LANES * CHANNEL_BITS;
  localparam int CFG_IDX_W    = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd2;

  typedef logic [NUM_LANES-1:0][CHANNEL_BITS-1:0] pix4_t;

  typedef struct packed {
    logic                    first_of_frame;
    logic [CHANNEL_BITS-1:0] red;
    logic [CHANNEL_BITS-1:0] green;
    logic [CHANNEL_BITS-1:0] blue;
    logic [CHANNEL_BITS-1:0] alpha;
  } in_pixel_t;

  typedef struct packed {
    logic [CHANNEL_BITS-1:0] out_red;
    logic [CHANNEL_BITS-1:0] out_green;
    logic [CHANNEL_BITS-1:0] out_blue;
    logic [CHANNEL_BITS-1:0] out_alpha;
    logic                    end_of_row;
    logic                    end_of_frame;
  } out_pixel_t;

  typedef enum logic [2:0] {
    LANE_HOLD,
    LANE_CLEAR,
    LANE_ADD,
    LANE_MUL,
    LANE_BACK,
    LANE_FIX
  } lane_op_t;

  typedef struct packed {
    lane_op_t op;
    logic     [RAD_W-1:0] radius;
  } lane_ctl_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HACC,
    ST_HMUL,
    ST_HBACK,
    ST_HFIX,
    ST_HWRITE,
    ST_VACC,
    ST_VDRAIN,
    ST_VMUL,
    ST_VBACK,
    ST_VFIX,
    ST_DONE
  } state_t;

  // floor(2^32 / (2r+1)): estimate is exact or one low
  function automatic logic [RECIP_W-1:0] recip(input logic [RAD_W-1:0] r);
    logic [RECIP_W-1:0] m;
    unique case (r)
      4'd0:  m = 33'd4294967296;
      4'd1:  m = 33'd1431655765;
      4'd2:  m = 33'd858993459;
      4'd3:  m = 33'd613566756;
      4'd4:  m = 33'd477218588;
      4'd5:  m = 33'd390451572;
      4'd6:  m = 33'd330382099;
      4'd7:  m = 33'd286331153;
      4'd8:  m = 33'd252645135;
      4'd9:  m = 33'd226050910;
      4'd10: m = 33'd204522252;
      4'd11: m = 33'd186737708;
      4'd12: m = 33'd171798691;
      4'd13: m = 33'd159072862;
      4'd14: m = 33'd148102320;
      4'd15: m = 33'd138547332;
    endcase
    return m;
  endfunction

endpackage

@@ rtl/sbb_ram.sv @@
module sbb_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/sbb_lane.sv @@
module sbb_lane (
  input  logic                              clk,
  input  sbb_pkg::lane_ctl_t                ctl,
  input  logic [sbb_pkg::CHANNEL_BITS-1:0]  sample,
  output logic [sbb_pkg::CHANNEL_BITS-1:0]  mean
);
  import sbb_pkg::*;

  logic [SUM_W-1:0]           acc;
  logic [SUM_W-1:0]           dividend;
  logic [SUM_W-1:0]           q_est;
  logic [SUM_W-1:0]           qn;
  logic [SUM_W-1:0]           biased;
  logic [SUM_W+RECIP_W-1:0]   prod;
  logic [SUM_W+SPAN_W-1:0]    qn_full;
  logic [SUM_W-1:0]           rem;
  logic [SUM_W-1:0]           q_fix;
  logic [SPAN_W-1:0]          span;

  // window size and rounding bias
  assign span    = {ctl.radius, 1'b1};
  assign biased  = acc + SUM_W'(ctl.radius);
  assign prod    = biased * recip(ctl.radius);
  assign qn_full = q_est * span;
  assign rem     = dividend - qn;
  assign q_fix   = (rem >= SUM_W'(span)) ? q_est + SUM_W'(1) : q_est;

  // accumulate the window, then divide by reciprocal with one correction
  always_ff @(posedge clk) begin
    unique case (ctl.op)
      LANE_HOLD: begin
      end
      LANE_CLEAR: begin
        acc <= '0;
      end
      LANE_ADD: begin
        acc <= acc + SUM_W'(sample);
      end
      LANE_MUL: begin
        dividend <= biased;
        q_est    <= prod[RECIP_SHIFT +: SUM_W];
      end
      LANE_BACK: begin
        qn <= qn_full[SUM_W-1:0];
      end
      LANE_FIX: begin
        mean <= q_fix[CHANNEL_BITS-1:0];
      end
    endcase
  end

endmodule

@@ rtl/separable_box_blur_rgba_top.sv @@
// Separable box blur of a raster-order RGBA pixel stream (valid region only).
// Input channel: in_valid / in_stall / in_pixel, one padded-frame pixel per
// request; first_of_frame restarts the column and row counters.
// Output channel: out_valid / out_stall / out_pixel, one mean pixel for each
// input pixel inside the valid region, end_of_row / end_of_frame marking the
// last pixel of an output row and of the frame.
// Configuration: cfg_valid / cfg_ready / cfg_index / cfg_data, always ready;
// index 0 radius, 1 frame_width, 2 frame_height. Write only while idle.
// Sequencing: a pixel outside the horizontal window range leaves the
// sequencer idle; one that yields a horizontal mean runs HACC, HMUL, HBACK,
// HFIX and HWRITE; one that yields an output then runs VACC, VDRAIN, VMUL,
// VBACK, VFIX and DONE, its result landing in the output register. The window
// sums walk over the pixel shift line and over the line store read port;
// four channel lanes run in parallel, each with its own reciprocal divider.
// A finished result waits in the output register while out_stall is high and
// the next pixel may already be accepted; the sequencer stalls before it
// would overwrite a result not yet taken.
// Reset (synchronous rst) restores radius 4, 2048 x 2048 and clears counters;
// the line store needs no clearing.
module separable_box_blur_rgba_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  sbb_pkg::in_pixel_t               in_pixel,
  output logic                             out_valid,
  input  logic                             out_stall,
  output sbb_pkg::out_pixel_t              out_pixel,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [sbb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sbb_pkg::DIM_W-1:0]        cfg_data
);
  import sbb_pkg::*;

  state_t state;
  state_t state_next;

  logic [RAD_W-1:0]  radius;
  logic [DIM_W-1:0]  frame_width;
  logic [DIM_W-1:0]  frame_height;

  logic [COL_W-1:0]  column_count;
  logic [DIM_W-1:0]  row_count;
  logic [SLOT_W-1:0] row_slot;

  pix4_t             shift_line [WIN_MAX];

  logic [COL_W-1:0]  ox;
  logic [SLOT_W-1:0] cur_slot;
  logic              go_v;
  logic              eor;
  logic              eof;
  logic [SLOT_W-1:0] k;
  logic [SLOT_W-1:0] rd_slot;
  logic              rd_valid;

  logic [DIM_W-1:0]  eff_w;
  logic [DIM_W-1:0]  eff_h;
  logic [SPAN_W-1:0] span;
  logic [SPAN_W-1:0] two_r;
  logic [COL_W-1:0]  x0;
  logic [DIM_W-1:0]  y0;
  logic [SLOT_W-1:0] slot0;
  logic [DIM_W-1:0]  x1;
  logic [DIM_W:0]    y1;
  logic              go_h;
  logic              accept;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_raddr;
  logic [PIX_W-1:0]  ram_rdata;
  pix4_t             ram_word;
  pix4_t             means;
  pix4_t             samples;
  lane_ctl_t         lane_ctl;
  lane_op_t          lane_op;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ST_IDLE);
  assign accept    = in_valid && !in_stall;

  // clamp configuration to usable values
  always_comb begin
    if (frame_width == '0) begin
      eff_w = DIM_W'(1);
    end else if (frame_width > DIM_W'(MAX_WIDTH)) begin
      eff_w = DIM_W'(MAX_WIDTH);
    end else begin
      eff_w = frame_width;
    end
    eff_h = (frame_height == '0) ? DIM_W'(1) : frame_height;
  end

  assign span  = {radius, 1'b1};
  assign two_r = {radius, 1'b0};

  // position of the incoming pixel
  always_comb begin
    x0    = in_pixel.first_of_frame ? '0 : column_count;
    y0    = in_pixel.first_of_frame ? '0 : row_count;
    slot0 = in_pixel.first_of_frame ? '0 : row_slot;
    if (DIM_W'(x0) >= eff_w) begin
      x0 = '0;
    end
    if (y0 >= eff_h) begin
      y0    = '0;
      slot0 = '0;
    end
    x1   = DIM_W'(x0) + DIM_W'(1);
    y1   = {1'b0, y0} + (DIM_W+1)'(1);
    go_h = (DIM_W'(span) <= eff_w) && (DIM_W'(span) <= eff_h) && (x0 >= COL_W'(two_r));
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      radius       <= RAD_W'(4);
      frame_width  <= DIM_W'(2048);
      frame_height <= DIM_W'(2048);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_RADIUS:       radius       <= cfg_data[RAD_W-1:0];
        CFG_FRAME_WIDTH:  frame_width  <= cfg_data;
        CFG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // advance position counters on each request
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      row_slot     <= '0;
    end else if (accept) begin
      if (x1 >= eff_w) begin
        column_count <= '0;
        if (y1 >= {1'b0, eff_h}) begin
          row_count <= '0;
          row_slot  <= '0;
        end else begin
          row_count <= y1[DIM_W-1:0];
          row_slot  <= (slot0 == SLOT_W'(WIN_MAX - 1)) ? '0 : slot0 + SLOT_W'(1);
        end
      end else begin
        column_count <= x1[COL_W-1:0];
        row_count    <= y0;
        row_slot     <= slot0;
      end
    end
  end

  // pixel shift line: tap k holds the pixel k columns back
  always_ff @(posedge clk) begin
    if (accept) begin
      shift_line[0] <= {in_pixel.alpha, in_pixel.blue, in_pixel.green, in_pixel.red};
      for (int i = 1; i < WIN_MAX; i++) begin
        shift_line[i] <= shift_line[i-1];
      end
    end
  end

  // latch per-request position data
  always_ff @(posedge clk) begin
    if (accept) begin
      ox       <= x0 - COL_W'(two_r);
      cur_slot <= slot0;
      go_v     <= (y0 >= DIM_W'(two_r));
      eor      <= (DIM_W'(x0) == eff_w - DIM_W'(1));
      eof      <= (DIM_W'(x0) == eff_w - DIM_W'(1)) && (y0 == eff_h - DIM_W'(1));
    end
  end

  // window step counter and line store read slot
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= (state == ST_VACC);
    end
    unique case (state)
      ST_HACC, ST_VACC: begin
        k       <= k + SLOT_W'(1);
        rd_slot <= (rd_slot == '0) ? SLOT_W'(WIN_MAX - 1) : rd_slot - SLOT_W'(1);
      end
      default: begin
        k       <= '0;
        rd_slot <= cur_slot;
      end
    endcase
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and lane control
  always_comb begin
    state_next = state;
    lane_op    = LANE_HOLD;
    ram_we     = 1'b0;
    samples    = shift_line[k];
    unique case (state)
      ST_IDLE: begin
        lane_op = LANE_CLEAR;
        if (accept && go_h) begin
          state_next = ST_HACC;
        end
      end
      ST_HACC: begin
        lane_op = LANE_ADD;
        if (k == SLOT_W'(two_r)) begin
          state_next = ST_HMUL;
        end
      end
      ST_HMUL: begin
        lane_op    = LANE_MUL;
        state_next = ST_HBACK;
      end
      ST_HBACK: begin
        lane_op    = LANE_BACK;
        state_next = ST_HFIX;
      end
      ST_HFIX: begin
        lane_op    = LANE_FIX;
        state_next = ST_HWRITE;
      end
      ST_HWRITE: begin
        lane_op    = LANE_CLEAR;
        ram_we     = 1'b1;
        state_next = go_v ? ST_VACC : ST_IDLE;
      end
      ST_VACC: begin
        samples = ram_word;
        lane_op = rd_valid ? LANE_ADD : LANE_HOLD;
        if (k == SLOT_W'(two_r)) begin
          state_next = ST_VDRAIN;
        end
      end
      ST_VDRAIN: begin
        samples    = ram_word;
        lane_op    = LANE_ADD;
        state_next = ST_VMUL;
      end
      ST_VMUL: begin
        lane_op    = LANE_MUL;
        state_next = ST_VBACK;
      end
      ST_VBACK: begin
        lane_op    = LANE_BACK;
        state_next = ST_VFIX;
      end
      ST_VFIX: begin
        lane_op    = LANE_FIX;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid || !out_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign lane_ctl = '{op: lane_op, radius: radius};

  // one divider lane per channel
  for (genvar c = 0; c < NUM_LANES; c++) begin : g_lane
    sbb_lane u_lane (
      .clk    (clk),
      .ctl    (lane_ctl),
      .sample (samples[c]),
      .mean   (means[c])
    );
  end

  // line store of horizontal means, one row slot per recent row
  assign ram_raddr = {rd_slot, ox};
  assign ram_word  = ram_rdata;

  sbb_ram #(
    .WIDTH (PIX_W),
    .DEPTH (STORE_DEPTH)
  ) u_line_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr ({cur_slot, ox}),
    .wdata (means),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // merge lane results into the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DONE && (!out_valid || !out_stall)) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && (!out_valid || !out_stall)) begin
      out_pixel.out_red      <= means[0];
      out_pixel.out_green    <= means[1];
      out_pixel.out_blue     <= means[2];
      out_pixel.out_alpha    <= means[3];
      out_pixel.end_of_row   <= eor;
      out_pixel.end_of_frame <= eof;
    end
  end

endmodule

@@ sim/tb_separable_box_blur_rgba_top.sv @@
module tb_separable_box_blur_rgba_top;
  timeunit 1ns;
  timeprecision 1ps;
  import sbb_pkg::*;

  // Blur predictor plus the queue of pixels it expects from the block
  class blur_scoreboard;
    int unsigned rad, fw, fh;
    int unsigned col, row;
    logic [15:0] hwin[31][4];
    logic [15:0] hmeans[int];
    out_pixel_t pending[$];
    int errors;
    int seen;

    function new();
      rad = 4; fw = 2048; fh = 2048;
      col = 0; row = 0;
      errors = 0; seen = 0;
      foreach (hwin[i, c]) hwin[i][c] = '0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] val);
      case (idx)
        CFG_RADIUS:       rad = val[3:0];
        CFG_FRAME_WIDTH:  fw = val;
        CFG_FRAME_HEIGHT: fh = val;
        default: ;
      endcase
    endfunction

    // Advance the window position for one accepted request
    function void note_request(in_pixel_t p);
      int unsigned r, n, w, h, x, y, ox, s;
      logic [15:0] px[4];
      out_pixel_t o;
      r = (rad > MAX_RADIUS) ? MAX_RADIUS : rad;
      n = 2 * r + 1;
      w = (fw == 0) ? 1 : fw;
      h = (fh == 0) ? 1 : fh;
      if (w > MAX_WIDTH) w = MAX_WIDTH;
      if (p.first_of_frame) begin
        col = 0;
        row = 0;
      end
      if (col >= w) col = 0;
      if (row >= h) row = 0;
      x = col;
      y = row;
      px[0] = p.red; px[1] = p.green; px[2] = p.blue; px[3] = p.alpha;
      for (int c = 0; c < 4; c++) hwin[x % 31][c] = px[c];
      if (n <= w && n <= h && x >= 2 * r) begin
        ox = x - 2 * r;
        for (int c = 0; c < 4; c++) begin
          s = 0;
          for (int k = 0; k < n; k++) s += hwin[(x - k) % 31][c];
          hmeans[((y % 31) * MAX_WIDTH + ox) * 4 + c] = (s + r) / n;
        end
        if (y >= 2 * r) begin
          logic [15:0] m[4];
          for (int c = 0; c < 4; c++) begin
            s = 0;
            for (int k = 0; k < n; k++)
              s += hmeans[(((y - k) % 31) * MAX_WIDTH + ox) * 4 + c];
            m[c] = (s + r) / n;
          end
          o.out_red = m[0]; o.out_green = m[1]; o.out_blue = m[2]; o.out_alpha = m[3];
          o.end_of_row = (x == w - 1);
          o.end_of_frame = (x == w - 1) && (y == h - 1);
          pending.push_back(o);
        end
      end
      x++;
      if (x >= w) begin
        x = 0;
        y++;
        if (y >= h) y = 0;
      end
      col = x;
      row = y;
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endtask

    // Compare one delivered pixel with the oldest expectation
    task check_pixel(out_pixel_t got);
      out_pixel_t e;
      seen++;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("unexpected pixel %h", got));
        return;
      end
      e = pending.pop_front();
      if (got.out_red !== e.out_red)
        report_mismatch($sformatf("red %h want %h", got.out_red, e.out_red));
      if (got.out_green !== e.out_green)
        report_mismatch($sformatf("green %h want %h", got.out_green, e.out_green));
      if (got.out_blue !== e.out_blue)
        report_mismatch($sformatf("blue %h want %h", got.out_blue, e.out_blue));
      if (got.out_alpha !== e.out_alpha)
        report_mismatch($sformatf("alpha %h want %h", got.out_alpha, e.out_alpha));
      if (got.end_of_row !== e.end_of_row)
        report_mismatch($sformatf("end_of_row %b want %b", got.end_of_row, e.end_of_row));
      if (got.end_of_frame !== e.end_of_frame)
        report_mismatch($sformatf("end_of_frame %b want %b",
                                  got.end_of_frame, e.end_of_frame));
    endtask
  endclass

  logic clk = 0;
  logic rst;
  logic in_valid, in_stall, out_valid, out_stall, cfg_valid, cfg_ready;
  in_pixel_t in_pixel;
  out_pixel_t out_pixel;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DIM_W-1:0] cfg_data;

  blur_scoreboard sb = new();
  bit calm;
  bit hold_req;
  int unsigned sent;

  separable_box_blur_rgba_top u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_pixel(in_pixel),
    .out_valid(out_valid), .out_stall(out_stall), .out_pixel(out_pixel),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // Check every pixel taken from the block
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_pixel(out_pixel);
  end

  // Stall the output at random, with one long hold on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_stall <= calm ? 1'b0 : ($urandom_range(99) < 30);
      end
    end
  end

  task write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task configure(int r, int w, int h);
    write_reg(CFG_RADIUS, DIM_W'(r));
    write_reg(CFG_FRAME_WIDTH, DIM_W'(w));
    write_reg(CFG_FRAME_HEIGHT, DIM_W'(h));
  endtask

  task send_pixel(bit fof, logic [15:0] rd, logic [15:0] gr, logic [15:0] bl,
                  logic [15:0] al);
    in_pixel_t p;
    p.first_of_frame = fof;
    p.red = rd; p.green = gr; p.blue = bl; p.alpha = al;
    while (!calm && $urandom_range(99) < 30) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pixel <= p;
    do @(posedge clk); while (in_stall);
    sb.note_request(p);
    sent++;
  endtask

  function logic [15:0] pick_chan();
    case ($urandom_range(7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task send_random(bit fof);
    send_pixel(fof, pick_chan(), pick_chan(), pick_chan(), pick_chan());
  endtask

  // Drop valid, drain expectations, then let any pixel still in work finish
  task settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  initial begin
    int r, w, h, len;
    in_valid = 1'b0;
    in_pixel = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_RADIUS;
    cfg_data = '0;
    calm = 1'b0;
    hold_req = 1'b0;
    sent = 0;
    rst = 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset geometry: only horizontal means, all-ones and all-zeros on red and green
    send_pixel(1'b1, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000);
    for (int i = 0; i < 11; i++)
      send_pixel(1'b0, (i % 2) ? 16'hFFFF : 16'h0000, 16'hFFFF, 16'h8000, 16'h0001);
    settle();

    // Width above the limit clamps to full line, radius 0, single row, no idling
    calm = 1'b1;
    configure(0, 4095, 1);
    for (int i = 0; i < 48; i++) send_random(i == 0);
    settle();
    calm = 1'b0;

    // Wide radius on the smallest frame that holds the window
    configure(10, 21, 21);
    for (int i = 0; i < 21 * 21; i++)
      send_pixel(i == 0, 16'hFFFF, (i % 3 == 0) ? 16'hFFFF : 16'h0000, pick_chan(),
                 16'hFFFF);
    settle();

    // Zero dimensions act as one pixel
    configure(0, 0, 0);
    for (int i = 0; i < 6; i++) send_random(i == 0);
    settle();

    // Tallest frame on a single column
    configure(0, 1, 4095);
    for (int i = 0; i < 8; i++) send_random(i == 0);
    settle();

    // Window wider than the frame never yields a pixel
    configure(15, 5, 5);
    for (int i = 0; i < 12; i++) send_random(i == 0);
    settle();

    // Random geometries with well-formed frames, cut frames and overruns
    hold_req = 1'b1;
    while (sent < 800) begin
      r = $urandom_range(3);
      w = 2 * r + 1 + $urandom_range(8);
      h = 2 * r + 1 + $urandom_range(5);
      if (w > 40) w = 40;
      configure(r, w, h);
      for (int f = 0; f < 2; f++) begin
        len = w * h;
        case ($urandom_range(9))
          0: len = $urandom_range(w * h);
          1: len = w * h + $urandom_range(2 * w);
          default: ;
        endcase
        for (int i = 0; i < len; i++)
          send_random(i == 0 || $urandom_range(99) < 2);
      end
      settle();
    end

    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Hard stop on a hung block
  initial begin
    #40ms;
    $display("Mismatches found");
    $finish;
  end

endmodule
